// ===== sv/lpm_pkg.sv =====
package lpm_pkg;

	// Pattern store size and derived widths
	localparam int PATTERN_MAX = 32;
	localparam int POS_W       = PATTERN_MAX + 1;
	localparam int LEN_W       = $clog2(PATTERN_MAX + 1);

	// Wildcard bytes
	localparam logic [7:0] CH_ONE = 8'h5F;
	localparam logic [7:0] CH_ANY = 8'h25;

	// Request function codes
	typedef enum logic [1:0] {
		FN_CLEAR  = 2'd0,
		FN_APPEND = 2'd1,
		FN_TEXT   = 2'd2,
		FN_END    = 2'd3
	} lpm_func_t;

	// Command from the input stage to the store and the automaton
	typedef struct packed {
		logic       clear;
		logic       append;
		logic       text;
		logic       finish;
		logic [7:0] data;
	} lpm_cmd_t;

	// Pattern as seen by the automaton
	typedef struct packed {
		logic [PATTERN_MAX-1:0][7:0] bytes;
		logic [PATTERN_MAX-1:0]      pct;
		logic [PATTERN_MAX-1:0]      one;
		logic [PATTERN_MAX-1:0]      vld;
		logic [LEN_W-1:0]            len;
		logic                        ovf;
	} lpm_pat_t;

	// Close a position set over '%' runs. Bit i+1 is reachable from bit i
	// when link[i+1] is set; this is a carry chain, so one add resolves it:
	// generate = seed, propagate = link.
	function automatic logic [POS_W-1:0] lpm_close(input logic [POS_W-1:0] seed,
		input logic [POS_W-1:0] link);
		logic [POS_W:0] x;
		logic [POS_W:0] y;
		logic [POS_W:0] s;
		logic [POS_W:0] c;
		x = {1'b0, seed | link};
		y = {1'b0, seed};
		s = x + y;
		c = s ^ x ^ y;
		return c[POS_W:1];
	endfunction

endpackage

// ===== sv/lpm_if.sv =====
// Request channel: one function code and one byte per request
interface lpm_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] func;
	logic [7:0] byte_value;

	modport source (output valid, output func, output byte_value, input ready);
	modport sink   (input valid, input func, input byte_value, output ready);
endinterface

// Result channel: one verdict per end-of-text request
interface lpm_out_if;
	logic valid;
	logic ready;
	logic matched;
	logic pattern_overflow;

	modport source (output valid, output matched, output pattern_overflow, input ready);
	modport sink   (input valid, input matched, input pattern_overflow, output ready);
endinterface

// ===== sv/lpm_pattern_store.sv =====
module lpm_pattern_store (
	input  logic             clk,
	input  logic             arst_n,
	input  lpm_pkg::lpm_cmd_t cmd,
	output lpm_pkg::lpm_pat_t pat
);
	import lpm_pkg::*;

	logic [PATTERN_MAX-1:0][7:0] bytes_q;
	logic [PATTERN_MAX-1:0]      pct_q;
	logic [PATTERN_MAX-1:0]      one_q;
	logic [PATTERN_MAX-1:0]      vld_q;
	logic [LEN_W-1:0]            len_q;
	logic                        ovf_q;
	logic                        full;

	assign full = (len_q == LEN_W'(PATTERN_MAX));

	// Entry payload: byte plus decoded wildcard flags, written at the fill point
	always_ff @(posedge clk) begin
		for (int i = 0; i < PATTERN_MAX; i++) begin
			if (cmd.append && !full && len_q == LEN_W'(i)) begin
				bytes_q[i] <= cmd.data;
				pct_q[i]   <= (cmd.data == CH_ANY);
				one_q[i]   <= (cmd.data == CH_ONE);
			end
		end
	end

	// Fill count, entry valid bits and overflow
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			vld_q <= '0;
			ovf_q <= 1'b0;
		end else if (cmd.clear) begin
			len_q <= '0;
			vld_q <= '0;
			ovf_q <= 1'b0;
		end else if (cmd.append) begin
			if (full) begin
				ovf_q <= 1'b1;
			end else begin
				len_q <= len_q + LEN_W'(1);
				for (int i = 0; i < PATTERN_MAX; i++) begin
					if (len_q == LEN_W'(i)) vld_q[i] <= 1'b1;
				end
			end
		end
	end

	assign pat.bytes = bytes_q;
	assign pat.pct   = pct_q;
	assign pat.one   = one_q;
	assign pat.vld   = vld_q;
	assign pat.len   = len_q;
	assign pat.ovf   = ovf_q;

endmodule

// ===== sv/lpm_automaton.sv =====
module lpm_automaton (
	input  logic              clk,
	input  logic              arst_n,
	input  lpm_pkg::lpm_cmd_t cmd,
	input  lpm_pkg::lpm_pat_t pat,
	output logic              hit
);
	import lpm_pkg::*;

	// Seed set before '%' closure; closure is applied against the live pattern
	logic [POS_W-1:0]       seed_q;
	logic [POS_W-1:0]       link;
	logic [POS_W-1:0]       closed;
	logic [POS_W-1:0]       next_seed;
	logic [PATTERN_MAX-1:0] live;
	logic [PATTERN_MAX-1:0] stay;
	logic [PATTERN_MAX-1:0] fwd;

	assign link   = {pat.pct & pat.vld, 1'b0};
	assign closed = lpm_close(seed_q, link);

	// One text byte: '%' holds its position, a matching byte or '_' moves on
	always_comb begin
		for (int i = 0; i < PATTERN_MAX; i++) begin
			live[i] = closed[i] & pat.vld[i];
			stay[i] = live[i] & pat.pct[i];
			fwd[i]  = live[i] & ~pat.pct[i] & (pat.one[i] | (pat.bytes[i] == cmd.data));
		end
		next_seed = {1'b0, stay} | {fwd, 1'b0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= POS_W'(1);
		end else if (cmd.clear || cmd.append || cmd.finish) begin
			seed_q <= POS_W'(1);
		end else if (cmd.text) begin
			seed_q <= next_seed;
		end
	end

	// Whole text consumed by the whole pattern, and the pattern did not overflow
	assign hit = closed[pat.len] & ~pat.ovf;

endmodule

// ===== sv/sql_like_pattern_matcher.sv =====
// Channel | Dir | Fields                      | Moves
// inp     | in  | func[1:0], byte_value[7:0]  | one request: clear, append, text byte, end
// res     | out | matched, pattern_overflow   | one verdict per end-of-text request
//
// One request per cycle sustained while no end request waits behind a stalled verdict;
// a verdict is offered once its end-of-text request has passed the input register, then the result register.
// All pattern positions update together; '%' closure is a single add.
// Reset clears the pattern length, overflow flag, automaton and both stages.
// A stalled verdict holds inp.ready low only while an end request waits behind it.
module sql_like_pattern_matcher (
	input  logic      clk,
	input  logic      arst_n,
	lpm_in_if.sink    inp,
	lpm_out_if.source res
);
	import lpm_pkg::*;

	logic      valid_s1;
	lpm_func_t func_s1;
	logic [7:0] byte_s1;
	logic      advance;
	logic      res_valid_q;
	logic      matched_q;
	logic      ovf_q;
	logic      hit;
	lpm_cmd_t  cmd;
	lpm_pat_t  pat;

	// Input stage advances unless an end request is blocked by a full result
	assign advance   = valid_s1 && !(func_s1 == FN_END && res_valid_q && !res.ready);
	assign inp.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (inp.ready) begin
			valid_s1 <= inp.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (inp.valid && inp.ready) begin
			func_s1 <= lpm_func_t'(inp.func);
			byte_s1 <= inp.byte_value;
		end
	end

	// Decode the staged request
	always_comb begin
		cmd.clear  = advance && func_s1 == FN_CLEAR;
		cmd.append = advance && func_s1 == FN_APPEND;
		cmd.text   = advance && func_s1 == FN_TEXT;
		cmd.finish = advance && func_s1 == FN_END;
		cmd.data   = byte_s1;
	end

	lpm_pattern_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.pat    (pat)
	);

	lpm_automaton u_auto (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.pat    (pat),
		.hit    (hit)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			matched_q <= hit;
			ovf_q     <= pat.ovf;
		end
	end

	assign res.valid            = res_valid_q;
	assign res.matched          = matched_q;
	assign res.pattern_overflow = ovf_q;

endmodule

// ===== sv/lpm_checker.sv =====
module lpm_checker (
	input logic clk,
	input logic arst_n,
	input logic in_ready,
	input logic res_valid,
	input logic res_ready,
	input logic matched,
	input logic pattern_overflow
);

	// A held verdict stays offered
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("verdict dropped while stalled");

	// A held verdict keeps its value
	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> $stable({matched, pattern_overflow}))
		else $error("verdict changed while stalled");

	// Overflow forces no match
	a_ovf_nomatch: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !(matched && pattern_overflow))
		else $error("match reported with overflow");

	// Requests are refused only behind a stalled verdict
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> res_valid && !res_ready)
		else $error("request channel stalled without result backpressure");

endmodule

bind sql_like_pattern_matcher lpm_checker u_lpm_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.in_ready         (inp.ready),
	.res_valid        (res.valid),
	.res_ready        (res.ready),
	.matched          (res.matched),
	.pattern_overflow (res.pattern_overflow)
);

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;
	import lpm_pkg::*;

	localparam int QUIET_LIMIT  = 2000;
	localparam int RANDOM_ITEMS = 1650;

	// Expected end-of-text verdict
	typedef struct packed {
		logic matched;
		logic overflow;
	} verdict_t;

	// Bit-parallel LIKE automaton plus the queue of verdicts still owed by the block
	class verdict_board;
		logic [7:0]       pat [PATTERN_MAX];
		int unsigned      plen;
		logic [POS_W-1:0] live;
		bit               ovf;
		verdict_t         due[$];
		int               errors;
		int               checked;
		int               hits;
		int               ovf_seen;

		function new();
			plen = 0;
			ovf = 0;
			errors = 0;
			checked = 0;
			hits = 0;
			ovf_seen = 0;
			foreach (pat[i]) pat[i] = 8'h00;
			rearm();
		endfunction

		// Let every live position before a '%' also reach the one after it
		function void close_percent();
			for (int i = 0; i < plen; i++)
				if (live[i] && pat[i] == CH_ANY) live[i+1] = 1'b1;
		endfunction

		function void rearm();
			live = '0;
			live[0] = 1'b1;
			close_percent();
		endfunction

		// Consume one text byte at every live position at once
		function void feed(logic [7:0] c);
			logic [POS_W-1:0] nxt;
			nxt = '0;
			for (int i = 0; i < plen; i++) begin
				if (live[i]) begin
					if (pat[i] == CH_ANY) nxt[i] = 1'b1;
					else if (pat[i] == CH_ONE || pat[i] == c) nxt[i+1] = 1'b1;
				end
			end
			live = nxt;
			close_percent();
		endfunction

		function void note_request(lpm_func_t f, logic [7:0] b);
			verdict_t v;
			case (f)
				FN_CLEAR: begin
					plen = 0;
					ovf = 0;
					rearm();
				end
				FN_APPEND: begin
					if (plen < PATTERN_MAX) begin
						pat[plen] = b;
						plen++;
					end else begin
						ovf = 1;
					end
					rearm();
				end
				FN_TEXT: feed(b);
				default: begin
					v.matched = !ovf && live[plen];
					v.overflow = ovf;
					due.push_back(v);
					rearm();
				end
			endcase
		endfunction

		function void check_verdict(logic m, logic o);
			verdict_t want;
			checked++;
			if (due.size() == 0) begin
				$error("verdict with none owed: matched=%0b pattern_overflow=%0b", m, o);
				errors++;
				return;
			end
			want = due.pop_front();
			if (want.matched) hits++;
			if (want.overflow) ovf_seen++;
			if (m !== want.matched) begin
				$error("matched: expected %0b, got %0b", want.matched, m);
				errors++;
			end
			if (o !== want.overflow) begin
				$error("pattern_overflow: expected %0b, got %0b", want.overflow, o);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	lpm_in_if  inp_ch ();
	lpm_out_if res_ch ();

	sql_like_pattern_matcher DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.inp    (inp_ch),
		.res    (res_ch)
	);

	verdict_board sb = new();
	int burst_left = 0;
	int requests   = 0;

	// Clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Known values on every input from time zero
	initial begin
		arst_n = 1'b0;
		inp_ch.valid = 1'b0;
		inp_ch.func = FN_CLEAR;
		inp_ch.byte_value = 8'h00;
		res_ch.ready = 1'b0;
	end

	// Offer one request; the sender may idle between bursts of random length
	task automatic push(input lpm_func_t f, input logic [7:0] b);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				@(negedge clk);
				inp_ch.valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
				: $urandom_range(1, 24);
		end
		burst_left--;
		@(negedge clk);
		inp_ch.valid <= 1'b1;
		inp_ch.func <= f;
		inp_ch.byte_value <= b;
		@(posedge clk);
		while (!inp_ch.ready) @(posedge clk);
		sb.note_request(f, b);
		requests++;
	endtask

	function automatic logic [7:0] text_char();
		if ($urandom_range(0, 99) < 85) return ($urandom_range(0, 1) != 0) ? "b" : "a";
		return 8'($urandom);
	endfunction

	function automatic logic [7:0] pattern_char();
		int r;
		r = $urandom_range(0, 99);
		if (r < 30) return CH_ANY;
		if (r < 50) return CH_ONE;
		if (r < 90) return ($urandom_range(0, 1) != 0) ? "b" : "a";
		return 8'($urandom);
	endfunction

	// One pattern load followed by one to four texts, mostly built to match, or now and then one random request
	task automatic run_case();
		logic [7:0] pq[$];
		logic [7:0] tq[$];
		int r;
		int len;
		int pos;
		if ($urandom_range(0, 7) == 0) begin
			push(lpm_func_t'($urandom_range(0, 3)), 8'($urandom));
			return;
		end
		push(FN_CLEAR, 8'($urandom));
		r = $urandom_range(0, 99);
		if (r < 70) len = $urandom_range(0, 6);
		else if (r < 90) len = $urandom_range(7, 16);
		else if (r < 96) len = $urandom_range(17, PATTERN_MAX);
		else len = $urandom_range(PATTERN_MAX + 1, PATTERN_MAX + 4);
		for (int i = 0; i < len; i++) begin
			pq.push_back(pattern_char());
			push(FN_APPEND, pq[i]);
		end
		repeat ($urandom_range(1, 4)) begin
			tq.delete();
			for (int i = 0; i < pq.size() && i < PATTERN_MAX; i++) begin
				if (pq[i] == CH_ANY) repeat ($urandom_range(0, 3)) tq.push_back(text_char());
				else if (pq[i] == CH_ONE) tq.push_back(text_char());
				else tq.push_back(pq[i]);
			end
			// Near misses
			if ($urandom_range(0, 2) == 0) begin
				r = $urandom_range(0, 2);
				if (r == 0 && tq.size() > 0) begin
					pos = $urandom_range(0, tq.size() - 1);
					tq[pos] = text_char();
				end else if (r == 1 && tq.size() > 0) begin
					void'(tq.pop_back());
				end else begin
					tq.push_back(text_char());
				end
			end
			foreach (tq[i]) begin
				// An append mid-text rearms the automaton
				if ($urandom_range(0, 79) == 0) push(FN_APPEND, pattern_char());
				push(FN_TEXT, tq[i]);
			end
			push(FN_END, 8'($urandom));
		end
	endtask

	// Result sampling
	initial begin
		forever begin
			@(posedge clk);
			if (res_ch.valid && res_ch.ready)
				sb.check_verdict(res_ch.matched, res_ch.pattern_overflow);
		end
	end

	// Receiver stall pattern, with one long hold-off to back up the input
	initial begin
		int mode;
		int mode_left;
		int hold;
		int phase;
		bit held;
		mode = 0;
		mode_left = 0;
		hold = 0;
		phase = 0;
		held = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!held && sb.checked >= 30) begin
				held = 1;
				hold = 150;
			end
			if (mode_left == 0) begin
				mode = $urandom_range(0, 2);
				mode_left = $urandom_range(32, 200);
			end
			mode_left--;
			phase++;
			if (hold > 0) begin
				hold--;
				res_ch.ready <= 1'b0;
			end else begin
				case (mode)
					0: res_ch.ready <= 1'b1;
					1: res_ch.ready <= ($urandom_range(0, 3) != 0);
					default: res_ch.ready <= ((phase % 7) < 3);
				endcase
			end
		end
	end

	// Watchdog on cycles with no request or verdict moving
	initial begin
		int quiet;
		quiet = 0;
		@(posedge arst_n);
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((inp_ch.valid && inp_ch.ready) || (res_ch.valid && res_ch.ready)) quiet = 0;
			else quiet++;
		end
		$display("FAIL sql_like_pattern_matcher");
		$finish;
	end

	// Main sequence
	initial begin
		int start_count;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: empty pattern against empty and non-empty text
		push(FN_END, 8'hFF);
		push(FN_TEXT, 8'h00);
		push(FN_END, 8'h00);
		// All-percent pattern matches empty text
		push(FN_CLEAR, 8'hFF);
		push(FN_APPEND, CH_ANY);
		push(FN_APPEND, CH_ANY);
		push(FN_END, 8'h5A);
		// Percent then literal
		push(FN_APPEND, "a");
		push(FN_TEXT, 8'hFF);
		push(FN_TEXT, "a");
		push(FN_END, 8'hA5);
		// Append while text in progress forgets the text already seen
		push(FN_TEXT, "z");
		push(FN_APPEND, CH_ONE);
		push(FN_TEXT, "a");
		push(FN_TEXT, 8'h00);
		push(FN_END, 8'h00);
		// Empty text against a pattern that needs a byte
		push(FN_END, 8'hFF);
		// Single-byte wildcard against too short and too long text
		push(FN_CLEAR, 8'h00);
		push(FN_APPEND, CH_ONE);
		push(FN_END, 8'h00);
		push(FN_TEXT, 8'hFF);
		push(FN_TEXT, 8'hFF);
		push(FN_END, 8'hFF);

		// Random part
		start_count = requests;
		while (requests - start_count < RANDOM_ITEMS) run_case();

		@(negedge clk);
		inp_ch.valid <= 1'b0;
		while (sb.due.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);

		$display("Run covered %0d requests and %0d verdicts (%0d matches, %0d overflowed).",
			requests, sb.checked, sb.hits, sb.ovf_seen);
		if (sb.errors == 0 && sb.due.size() == 0) begin
			$display("PASS sql_like_pattern_matcher");
		end else begin
			$display("FAIL sql_like_pattern_matcher");
		end
		$finish;
	end

endmodule
